FILE: sv/cpb_pkg.sv
// Shared types and constants of the coincidence pair builder.
// No dependencies; imported by every module of the block.
package cpb_pkg;

    localparam int CHAN_W     = 4;
    localparam int ENERGY_W   = 16;
    localparam int TIME_W     = 32;
    localparam int MULT_W     = 5;
    localparam int WINDOW_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_PAIRS  = 12;
    localparam int PAIR_CNT_W = $clog2(MAX_PAIRS + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MULTIPLICITY = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic [ENERGY_W-1:0]        energy;
        logic signed [TIME_W-1:0]   time_stamp;
        logic [MULT_W-1:0]          multiplicity;
    } t_in_item;

    typedef struct packed {
        logic [ENERGY_W-1:0] high_energy;
        logic [ENERGY_W-1:0] low_energy;
        logic [CHAN_W-1:0]   first_channel;
        logic [CHAN_W-1:0]   second_channel;
        logic                last_pair;
    } t_out_item;

    // Verdict of the shared compare unit on one stored partner.
    typedef struct packed {
        logic                hit;
        logic [ENERGY_W-1:0] high_energy;
        logic [ENERGY_W-1:0] low_energy;
    } t_cmp_res;

endpackage

FILE: sv/coincidence_pair_builder_unit.sv
// Top level of the coincidence pair builder: sequencer, configuration and output register.
// Depends on cpb_pkg, cpb_store and cpb_cmp.

// Each input transaction carries one detector channel reading; readings of one
// event arrive in ascending channel order, and a channel that is not above the
// previous one starts a new event. The reading is written into the channel store
// as it is accepted. If its multiplicity reaches min_multiplicity and its energy is
// above energy_threshold, the sequencer then walks the lower channels one per cycle,
// unless a stalled output holds it, through a single shared compare unit and emits
// one output transaction per qualifying partner (different group of GROUP_SIZE
// channels, both energies above the threshold, energies not equal, absolute time
// difference within time_window), with the last one of the item flagged by
// last_pair. A walked reading is accepted, then the store reads are issued one per
// cycle unless a stalled output holds the walk, set by the single read port feeding
// the compare unit, then the last partner is compared, the walk is closed and the final
// pair is handed to the output register. A finished pair that cannot move on because
// the output is stalled holds the walk; a walk that reaches MAX_PAIRS pairs ends early.
// Input stall is high for the whole walk. Readings with a channel of CHANNELS or more
// are accepted and dropped. No clearing pass is needed after reset: data read from the
// store is only used for entries marked valid for the current event.
module coincidence_pair_builder_unit #(
    parameter int CHANNELS   = 16,
    parameter int GROUP_SIZE = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cpb_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cpb_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [cpb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cpb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cpb_pkg::*;

    localparam int             ADDR_W   = $clog2(CHANNELS);
    localparam logic [6:0]     CH_LIMIT = 7'(CHANNELS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } t_state;

    t_state                  r_state;
    t_in_item                r_item;
    logic [CHANNELS-1:0]     r_mask;
    logic [CHAN_W-1:0]       r_walk;
    logic [CHAN_W-1:0]       r_j;
    logic                    r_chk_v;
    logic [CHAN_W-1:0]       r_chk_j;
    logic [PAIR_CNT_W-1:0]   r_count;
    logic                    r_pend_v;
    t_out_item               r_pend;
    logic                    r_out_valid;
    t_out_item               r_out;
    logic [ENERGY_W-1:0]     r_thr;
    logic [WINDOW_W-1:0]     r_win;
    logic [MULT_W-1:0]       r_min;

    logic                    w_accept;
    logic                    w_in_range;
    logic                    w_pass_in;
    logic [6:0]              w_in_ch_ext;
    logic [6:0]              w_j_ext;
    logic [6:0]              w_chk_ext;
    logic [ADDR_W-1:0]       w_in_addr;
    logic [ADDR_W-1:0]       w_j_addr;
    logic [ADDR_W-1:0]       w_chk_addr;
    logic [CHANNELS-1:0]     w_mask_base;
    logic                    w_hit;
    logic                    w_out_busy;
    logic                    w_hold;
    logic                    w_issue;
    logic                    w_walk_done;
    logic                    w_below_cap;
    logic                    w_push_walk;
    logic                    w_push_last;
    t_out_item               w_new_pair;
    t_out_item               w_last_out;
    logic [ENERGY_W-1:0]     w_renergy;
    logic signed [TIME_W-1:0] w_rtime;
    t_cmp_res                w_cmp;

    always_comb begin
        w_in_ch_ext = {3'b000, i_in_data.channel};
        w_j_ext     = {3'b000, r_j};
        w_chk_ext   = {3'b000, r_chk_j};
        w_in_addr   = w_in_ch_ext[ADDR_W-1:0];
        w_j_addr    = w_j_ext[ADDR_W-1:0];
        w_chk_addr  = w_chk_ext[ADDR_W-1:0];

        w_accept   = i_in_valid && (r_state == S_IDLE);
        w_in_range = w_in_ch_ext < CH_LIMIT;
        w_pass_in  = (i_in_data.multiplicity >= r_min) && (i_in_data.energy > r_thr);

        // A channel that does not climb above the previous one opens a new event.
        w_mask_base = ((r_mask != '0) && (i_in_data.channel <= r_walk)) ? '0 : r_mask;

        w_below_cap = r_count < PAIR_CNT_W'(MAX_PAIRS);
        w_out_busy  = r_out_valid && i_out_stall;
        w_hit       = r_chk_v && w_cmp.hit && r_mask[w_chk_addr] && w_below_cap;
        // A second pair cannot be parked while the first still waits at the output.
        w_hold      = w_hit && r_pend_v && w_out_busy;
        w_issue     = (r_state == S_WALK) && !w_hold && (r_j != r_item.channel)
                      && w_below_cap;
        w_walk_done = !r_chk_v && ((r_j == r_item.channel) || !w_below_cap);

        // The parked pair moves to the output when a newer pair replaces it, or
        // with the last-pair flag set when the walk is over.
        w_push_walk = (r_state == S_WALK) && w_hit && r_pend_v && !w_hold;
        w_push_last = (r_state == S_FLUSH) && r_pend_v && !w_out_busy;

        w_new_pair.high_energy    = w_cmp.high_energy;
        w_new_pair.low_energy     = w_cmp.low_energy;
        w_new_pair.first_channel  = r_chk_j;
        w_new_pair.second_channel = r_item.channel;
        w_new_pair.last_pair      = 1'b0;

        w_last_out           = r_pend;
        w_last_out.last_pair = 1'b1;
    end

    cpb_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_accept && w_in_range),
        .i_waddr   (w_in_addr),
        .i_wenergy (i_in_data.energy),
        .i_wtime   (i_in_data.time_stamp),
        .i_re      (w_issue),
        .i_raddr   (w_j_addr),
        .o_renergy (w_renergy),
        .o_rtime   (w_rtime)
    );

    cpb_cmp #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_cmp (
        .i_channel        (r_item.channel),
        .i_energy         (r_item.energy),
        .i_time           (r_item.time_stamp),
        .i_partner        (r_chk_j),
        .i_partner_energy (w_renergy),
        .i_partner_time   (w_rtime),
        .i_threshold      (r_thr),
        .i_window         (r_win),
        .o_res            (w_cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_walk      <= '0;
            r_j         <= '0;
            r_chk_v     <= 1'b0;
            r_count     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= ENERGY_W'(2);
            r_win       <= WINDOW_W'(50);
            r_min       <= MULT_W'(2);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENERGY_THRESHOLD: r_thr <= i_cfg_data[ENERGY_W-1:0];
                    CFG_TIME_WINDOW:      r_win <= i_cfg_data[WINDOW_W-1:0];
                    CFG_MIN_MULTIPLICITY: r_min <= i_cfg_data[MULT_W-1:0];
                    default: ;
                endcase
            end

            if (w_push_walk || w_push_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && w_in_range) begin
                        r_item  <= i_in_data;
                        r_mask  <= w_mask_base
                                   | ({{(CHANNELS-1){1'b0}}, 1'b1} << w_in_addr);
                        r_walk  <= i_in_data.channel;
                        r_j     <= '0;
                        r_chk_v <= 1'b0;
                        r_count <= '0;
                        if (w_pass_in && (i_in_data.channel != '0)) begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (!w_hold) begin
                        if (w_hit) begin
                            if (r_pend_v) begin
                                r_out <= r_pend;
                            end
                            r_pend   <= w_new_pair;
                            r_pend_v <= 1'b1;
                            r_count  <= r_count + 1'b1;
                        end
                        r_chk_v <= w_issue;
                        r_chk_j <= r_j;
                        if (w_issue) begin
                            r_j <= r_j + 1'b1;
                        end
                        if (w_walk_done) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (!w_out_busy) begin
                        r_out    <= w_last_out;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A delivered pair always has strictly ordered energies.
    a_energy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.high_energy > o_out_data.low_energy))
        else $error("pair energies not strictly ordered");

    // The partner channel is always below the channel of the current reading.
    a_channel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.first_channel < o_out_data.second_channel))
        else $error("pair channels not ordered");

    // The pair counter never runs past the per-reading cap.
    a_pair_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PAIR_CNT_W'(MAX_PAIRS))
        else $error("pair count above cap");

    // No pair is left parked once the sequencer is back to idle.
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending pair left behind");

    // Leaving the flush step with a parked pair must present it as the last pair.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && r_pend_v && !w_out_busy) |=>
        (o_out_valid && o_out_data.last_pair))
        else $error("last pair not flagged");

endmodule

FILE: sv/cpb_store.sv
// Channel store of the coincidence pair builder: energy and timestamp per channel.
// Depends on cpb_pkg for field widths.
module cpb_store #(
    parameter int CHANNELS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(CHANNELS)-1:0]        i_waddr,
    input  logic [cpb_pkg::ENERGY_W-1:0]       i_wenergy,
    input  logic signed [cpb_pkg::TIME_W-1:0]  i_wtime,
    input  logic                               i_re,
    input  logic [$clog2(CHANNELS)-1:0]        i_raddr,
    output logic [cpb_pkg::ENERGY_W-1:0]       o_renergy,
    output logic signed [cpb_pkg::TIME_W-1:0]  o_rtime
);
    import cpb_pkg::*;

    logic [ENERGY_W-1:0]      r_energy_mem [CHANNELS];
    logic signed [TIME_W-1:0] r_time_mem   [CHANNELS];
    logic [ENERGY_W-1:0]      r_renergy;
    logic signed [TIME_W-1:0] r_rtime;

    // Entries are never cleared; the valid mask in the sequencer guards reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_energy_mem[i_waddr] <= i_wenergy;
            r_time_mem[i_waddr]   <= i_wtime;
        end
        if (i_re) begin
            r_renergy <= r_energy_mem[i_raddr];
            r_rtime   <= r_time_mem[i_raddr];
        end
    end

    assign o_renergy = r_renergy;
    assign o_rtime   = r_rtime;

endmodule

FILE: sv/cpb_cmp.sv
// Shared compare unit of the coincidence pair builder: tests one stored partner.
// Depends on cpb_pkg for field widths and the t_cmp_res result type.
module cpb_cmp #(
    parameter int GROUP_SIZE = 4
) (
    input  logic [cpb_pkg::CHAN_W-1:0]         i_channel,
    input  logic [cpb_pkg::ENERGY_W-1:0]       i_energy,
    input  logic signed [cpb_pkg::TIME_W-1:0]  i_time,
    input  logic [cpb_pkg::CHAN_W-1:0]         i_partner,
    input  logic [cpb_pkg::ENERGY_W-1:0]       i_partner_energy,
    input  logic signed [cpb_pkg::TIME_W-1:0]  i_partner_time,
    input  logic [cpb_pkg::ENERGY_W-1:0]       i_threshold,
    input  logic [cpb_pkg::WINDOW_W-1:0]       i_window,
    output cpb_pkg::t_cmp_res                  o_res
);
    import cpb_pkg::*;

    localparam int MAP_DEPTH = 1 << CHAN_W;

    // Group number of every possible channel index, worked out at elaboration.
    function automatic logic [MAP_DEPTH-1:0][CHAN_W-1:0] group_map();
        logic [MAP_DEPTH-1:0][CHAN_W-1:0] grp;
        grp = '0;
        for (int k = 0; k < MAP_DEPTH; k++) begin
            grp[CHAN_W'(k)] = CHAN_W'(k / GROUP_SIZE);
        end
        return grp;
    endfunction

    localparam logic [MAP_DEPTH-1:0][CHAN_W-1:0] GROUP_MAP = group_map();

    logic signed [TIME_W:0] w_diff;
    logic [TIME_W:0]        w_mag;
    logic                   w_same_group;
    logic                   w_in_window;
    logic                   w_partner_high;

    always_comb begin
        // The difference is taken one bit wider, so it never wraps.
        w_diff = {i_time[TIME_W-1], i_time} - {i_partner_time[TIME_W-1], i_partner_time};
        w_mag  = w_diff[TIME_W] ? (TIME_W+1)'(-w_diff) : w_diff;
        w_in_window    = w_mag <= {{(TIME_W + 1 - WINDOW_W){1'b0}}, i_window};
        w_same_group   = GROUP_MAP[i_partner] == GROUP_MAP[i_channel];
        w_partner_high = i_partner_energy > i_energy;

        o_res.hit = (i_partner_energy > i_threshold) && !w_same_group && w_in_window
                    && (i_partner_energy != i_energy);
        o_res.high_energy = w_partner_high ? i_partner_energy : i_energy;
        o_res.low_energy  = w_partner_high ? i_energy : i_partner_energy;
    end

endmodule

FILE: tb/coincidence_pair_builder_unit_test.sv
// Self-checking testbench for coincidence_pair_builder_unit: stimulus tasks, pair predictor
// and scoreboard class. Depends on cpb_pkg and on the RTL of the coincidence pair builder.
module coincidence_pair_builder_unit_test;

    import cpb_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int NUM_CHANNELS   = 16;
    localparam int CHAN_GROUP     = 4;
    // The drain wait covers the longest walk plus the output register with a wide
    // margin.
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 400;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int NUM_PHASES     = 7;

    // Register settings of the random phases, extremes included.
    localparam int unsigned PHASE_THR[NUM_PHASES]   = '{40, 0, 65535, 1000, 0, 12000, 2};
    localparam int unsigned PHASE_WIN[NUM_PHASES]   = '{300, 65535, 65535, 0, 20, 500, 50};
    localparam int unsigned PHASE_MULT[NUM_PHASES]  = '{2, 0, 16, 16, 1, 3, 2};
    localparam int unsigned PHASE_ITEMS[NUM_PHASES] = '{60, 60, 30, 40, 60, 60, 70};

    // Predicts the coincidence pairs of every accepted reading and checks the pairs
    // that leave the block against them, oldest first.
    class coincidence_scoreboard;
        logic [ENERGY_W-1:0]      energy_thr;
        logic [WINDOW_W-1:0]      time_win;
        logic [MULT_W-1:0]        min_mult;
        logic [ENERGY_W-1:0]      chan_energy[NUM_CHANNELS];
        logic signed [TIME_W-1:0] chan_time[NUM_CHANNELS];
        logic [NUM_CHANNELS-1:0]  event_mask;
        logic [CHAN_W-1:0]        last_channel;
        t_out_item                expected_pairs[$];
        int                       error_count;
        int                       readings_seen;
        int                       pairs_checked;

        function new();
            energy_thr    = 16'd2;
            time_win      = 16'd50;
            min_mult      = 5'd2;
            event_mask    = '0;
            last_channel  = '0;
            error_count   = 0;
            readings_seen = 0;
            pairs_checked = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_ENERGY_THRESHOLD: energy_thr = value;
                CFG_TIME_WINDOW:      time_win   = value;
                CFG_MIN_MULTIPLICITY: min_mult   = value[MULT_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the pairs that one accepted reading causes, then stores the reading.
        function void record_reading(t_in_item r);
            t_out_item item_pairs[$];
            t_out_item p;
            longint    diff;
            longint    now_ts;
            longint    then_ts;
            int        j;

            readings_seen++;
            // A channel that is not above the previous one opens a new event.
            if (event_mask != '0 && r.channel <= last_channel)
                event_mask = '0;
            if (r.multiplicity >= min_mult && r.energy > energy_thr) begin
                now_ts = $signed(r.time_stamp);
                for (j = 0; j < int'(r.channel) && item_pairs.size() < MAX_PAIRS; j++) begin
                    if (!event_mask[j])
                        continue;
                    if (chan_energy[j] <= energy_thr)
                        continue;
                    if (j / CHAN_GROUP == int'(r.channel) / CHAN_GROUP)
                        continue;
                    then_ts = chan_time[j];
                    diff = now_ts - then_ts;
                    if (diff < 0)
                        diff = -diff;
                    if (diff > longint'(time_win))
                        continue;
                    if (chan_energy[j] == r.energy)
                        continue;
                    p.high_energy    = (chan_energy[j] > r.energy) ? chan_energy[j] : r.energy;
                    p.low_energy     = (chan_energy[j] > r.energy) ? r.energy : chan_energy[j];
                    p.first_channel  = j[CHAN_W-1:0];
                    p.second_channel = r.channel;
                    p.last_pair      = 1'b0;
                    item_pairs.push_back(p);
                end
                if (item_pairs.size() > 0)
                    item_pairs[item_pairs.size()-1].last_pair = 1'b1;
                foreach (item_pairs[k])
                    expected_pairs.push_back(item_pairs[k]);
            end
            chan_energy[r.channel] = r.energy;
            chan_time[r.channel]   = r.time_stamp;
            event_mask[r.channel]  = 1'b1;
            last_channel           = r.channel;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_pair(t_out_item got);
            t_out_item want;

            if (expected_pairs.size() == 0) begin
                $error("pair (%0d,%0d) on channels %0d/%0d arrived with none expected",
                       got.high_energy, got.low_energy, got.first_channel, got.second_channel);
                error_count++;
                return;
            end
            want = expected_pairs.pop_front();
            pairs_checked++;
            compare_field("high_energy", want.high_energy, got.high_energy);
            compare_field("low_energy", want.low_energy, got.low_energy);
            compare_field("first_channel", want.first_channel, got.first_channel);
            compare_field("second_channel", want.second_channel, got.second_channel);
            compare_field("last_pair", want.last_pair, got.last_pair);
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Shared controls: random idling on both sides, and a one-shot request for the
    // receiver to hold off for a long stretch.
    bit idle_on       = 1'b1;
    bit long_hold_req = 1'b0;

    coincidence_scoreboard coinc_sb = new();

    coincidence_pair_builder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Every signal is sampled in the active region right at the rising edge, so the
    // values seen are the ones the flops capture; all drives are nonblocking.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            coinc_sb.check_pair(o_out_data);
    end

    // Receiver: stalls at random in about one cycle in ten while idling is enabled.
    // On request it holds the output off for a long stretch so that the pair walk
    // blocks and the input side backs up.
    initial begin : receiver
        int hold;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                for (hold = 0; hold < LONG_HOLD; hold++)
                    @(posedge i_clk);
            end
            i_out_stall <= idle_on && ($urandom_range(99) < 10);
        end
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_in_item make_reading(int unsigned ch, int unsigned en,
                                              logic [31:0] ts, int unsigned mult);
        t_in_item r;
        r.channel      = ch[CHAN_W-1:0];
        r.energy       = en[ENERGY_W-1:0];
        r.time_stamp   = ts;
        r.multiplicity = mult[MULT_W-1:0];
        return r;
    endfunction

    // Offers one reading and holds it until the block takes it. All tasks that drive
    // the block are entered right after a rising edge, so valid is only ever changed
    // once per edge.
    task automatic send_reading(input t_in_item r);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do
            @(posedge i_clk);
        while (o_in_stall);
        coinc_sb.record_reading(r);
        if (idle_on && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Lets every predicted pair come out, then waits out a walk that produces no pair.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (coinc_sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        coinc_sb.set_register(idx, value[CFG_DATA_W-1:0]);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Directed readings under the reset settings (threshold 2, window 50, multiplicity 2).
    task automatic run_directed();
        // One event: a same-group partner at the window edge (exactly 50 apart), at most one pair per item.
        send_reading(make_reading(0, 100, 0, 4));
        send_reading(make_reading(4, 200, 10, 4));
        send_reading(make_reading(5, 300, -40, 4));
        // Event boundary; partner in the same group; equal energies; energy at threshold.
        send_reading(make_reading(1, 100, 1000, 5));
        send_reading(make_reading(2, 500, 1000, 5));
        send_reading(make_reading(8, 100, 1000, 5));
        send_reading(make_reading(9, 2, 1000, 5));
        send_reading(make_reading(12, 3, 1051, 5));
        send_reading(make_reading(13, 600, 1050, 5));
        // Low multiplicity readings are stored but emit nothing; channel 11 at the minimum pairs with both.
        send_reading(make_reading(3, 400, 0, 1));
        send_reading(make_reading(7, 500, 0, 1));
        send_reading(make_reading(11, 600, 0, 2));
        // Field extremes: largest and smallest energy and timestamp, multiplicity 0 and 16.
        send_reading(make_reading(0, 65535, 32'h7FFF_FFFF, 16));
        send_reading(make_reading(4, 0, 32'h8000_0000, 16));
        send_reading(make_reading(8, 65534, 32'h7FFF_FFCD, 16));
        send_reading(make_reading(15, 3, 32'h8000_0000, 0));
        // The same channel again starts a new event on its own.
        send_reading(make_reading(15, 1000, 0, 2));
    endtask

    // Timestamp difference across the sign boundary must not wrap (window at 65535).
    task automatic run_wide_time();
        send_reading(make_reading(0, 10, 32'h7FFF_FFFF, 3));
        send_reading(make_reading(4, 20, 32'h8000_0000, 3));
        send_reading(make_reading(8, 30, 32'h7FFF_0000, 3));
        send_reading(make_reading(12, 0, 32'h7FFF_0000, 3));
    endtask

    // Mostly well-formed events with random content around the current settings,
    // the rest short runs of fully random readings.
    task automatic run_random(input int count);
        int           done;
        int           ch;
        int           density;
        int           hits;
        int unsigned  mult;
        int unsigned  en;
        int unsigned  prev_en;
        int unsigned  span;
        logic [31:0]  base_ts;
        logic [31:0]  ts;
        int           k;

        done = 0;
        while (done < count) begin
            if ($urandom_range(99) < 80) begin
                density = $urandom_range(20, 90);
                hits = 0;
                for (ch = 0; ch < NUM_CHANNELS; ch++)
                    if ($urandom_range(99) < density)
                        hits++;
                mult = ($urandom_range(99) < 75) ? hits : $urandom_range(0, 16);
                base_ts = $urandom();
                span = coinc_sb.time_win + coinc_sb.time_win / 4 + 2;
                prev_en = $urandom_range(0, 65535);
                for (ch = 0; ch < NUM_CHANNELS && hits > 0; ch++) begin
                    if ($urandom_range(NUM_CHANNELS - 1 - ch) >= hits)
                        continue;
                    hits--;
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: en = $urandom_range(0, 65535);
                        4, 5, 6: begin
                            en = coinc_sb.energy_thr + $urandom_range(1, 50);
                            if (en > 65535)
                                en = 65535;
                        end
                        7: en = prev_en;
                        8: en = coinc_sb.energy_thr;
                        default: en = $urandom_range(0, 1) ? 65535 : 0;
                    endcase
                    prev_en = en;
                    if ($urandom_range(99) < 10)
                        ts = $urandom();
                    else if ($urandom_range(99) < 15)
                        ts = base_ts;
                    else
                        ts = base_ts + $urandom_range(0, 2 * span) - span;
                    send_reading(make_reading(ch, en, ts, mult));
                    done++;
                end
            end else begin
                for (k = $urandom_range(1, 3); k > 0; k--) begin
                    send_reading(make_reading($urandom_range(0, 15), $urandom_range(0, 65535),
                                              $urandom(), $urandom_range(0, 16)));
                    done++;
                end
            end
        end
    endtask

    initial begin : main
        int ph;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_ENERGY_THRESHOLD, PHASE_THR[ph]);
            write_reg(CFG_TIME_WINDOW, PHASE_WIN[ph]);
            write_reg(CFG_MIN_MULTIPLICITY, PHASE_MULT[ph]);
            @(posedge i_clk);
            // The fifth phase runs with no idling on either side at all.
            idle_on = (ph != 4);
            if (ph == 1) begin
                run_wide_time();
                // Threshold, window and multiplicity are at their loosest in this phase, so a long
                // output hold-off fills the block and pushes back on the input.
                long_hold_req = 1'b1;
            end
            run_random(PHASE_ITEMS[ph]);
            drain();
        end

        $display("Run covered %0d readings over %0d register settings plus reset values.",
                 coinc_sb.readings_seen, NUM_PHASES);
        $display("%0d coincidence pairs were compared field by field.",
                 coinc_sb.pairs_checked);
        if (coinc_sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/cpb_pkg.sv
sv/cpb_store.sv
sv/cpb_cmp.sv
sv/coincidence_pair_builder_unit.sv
tb/coincidence_pair_builder_unit_test.sv
